FILE: src/ids_pkg.sv
// Shared types, constants and codes for the indexed deque store
package ids_pkg;

   localparam int Capacity  = 16;
   localparam int DataWidth = 32;
   localparam int IdxWidth  = $clog2(Capacity);
   localparam int CntWidth  = $clog2(Capacity + 1);

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_INSERT_AT  = 3'd2,
      CMD_REMOVE_AT  = 3'd3,
      CMD_POP_FRONT  = 3'd4,
      CMD_POP_BACK   = 3'd5,
      CMD_READ_AT    = 3'd6,
      CMD_FIND       = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_RANGE    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [4:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [3:0]         found_index;
      logic [4:0]         entry_count;
      logic [2:0]         status;
   } rsp_type;

   // datapath step selected by the controller; open or close is decoded in the datapath
   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_SHIFT  = 2'd1
   } op_type;

   typedef struct packed {
      logic   load;     // capture request
      op_type op;       // shift step in the cell chain
      logic   respond;  // form the result item
   } ctl_type;

   typedef struct packed {
      logic [CntWidth-1:0] count;
   } sts_type;

endpackage

FILE: src/indexed_deque_store_unit.sv
// Indexed deque store: top level joining controller and datapath
// An item is captured, then its result item is registered in the cell-chain shift step.
// No new item is taken until the last has passed its capture and cell-chain shift steps.
// A stalled result holds the next item in its shift step until the result is taken.
// Reset: synchronous, clears the count and handshake state; cell contents are not cleared.
module indexed_deque_store_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ids_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ids_pkg::rsp_type rsp_data
);

   ids_pkg::ctl_type ctl;
   ids_pkg::sts_type sts;
   logic             unused_count;

   ids_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .ctl
   );

   ids_datapath u_dp (
      .clock, .reset, .req_data, .ctl, .sts, .rsp_data
   );

   assign unused_count = ^sts.count;

endmodule

FILE: src/ids_datapath.sv
// Datapath: shifting cell chain of entries, count, operand registers, result
module ids_datapath (
   input  logic             clock,
   input  logic             reset,
   input  ids_pkg::req_type req_data,
   input  ids_pkg::ctl_type ctl,
   output ids_pkg::sts_type sts,
   output ids_pkg::rsp_type rsp_data
);

   localparam int N  = ids_pkg::Capacity;
   localparam int CW = ids_pkg::CntWidth;
   localparam int IW = ids_pkg::IdxWidth;

   logic [ids_pkg::DataWidth-1:0] cell_ff [N];
   logic [CW-1:0]                 count_ff, count_in;
   ids_pkg::req_type              req_ff;
   ids_pkg::rsp_type              rsp_ff;

   // decoded decision, from registered request and count
   logic [CW-1:0]                 gap_pos;
   logic                          do_open, do_close;
   ids_pkg::status_type           st;
   logic [ids_pkg::DataWidth-1:0] rd_val;
   logic [ids_pkg::DataWidth-1:0] sval;
   logic [IW-1:0]                 hit_idx;
   logic                          hit;
   logic [CW-1:0]                 pos_ext;

   assign sval    = ids_pkg::DataWidth'(req_ff.value);
   assign pos_ext = CW'(req_ff.position);

   // command decode
   always_comb begin
      do_open  = 1'b0;
      do_close = 1'b0;
      gap_pos  = '0;
      st       = ids_pkg::ST_OK;
      unique case (ids_pkg::cmd_type'(req_ff.command))
         ids_pkg::CMD_PUSH_FRONT, ids_pkg::CMD_PUSH_BACK, ids_pkg::CMD_INSERT_AT: begin
            if (count_ff >= CW'(N)) begin
               st = ids_pkg::ST_FULL;
            end else if (req_ff.command == ids_pkg::CMD_PUSH_FRONT) begin
               do_open = 1'b1;
            end else if (req_ff.command == ids_pkg::CMD_PUSH_BACK) begin
               do_open = 1'b1;
               gap_pos = count_ff;
            end else if (pos_ext > count_ff || req_ff.position > 5'(N)) begin
               st = ids_pkg::ST_RANGE;
            end else begin
               do_open = 1'b1;
               gap_pos = pos_ext;
            end
         end
         ids_pkg::CMD_REMOVE_AT, ids_pkg::CMD_READ_AT: begin
            if (count_ff == '0) begin
               st = ids_pkg::ST_EMPTY;
            end else if (pos_ext >= count_ff || req_ff.position >= 5'(N)) begin
               st = ids_pkg::ST_RANGE;
            end else begin
               do_close = (req_ff.command == ids_pkg::CMD_REMOVE_AT);
               gap_pos  = pos_ext;
            end
         end
         ids_pkg::CMD_POP_FRONT, ids_pkg::CMD_POP_BACK: begin
            if (count_ff == '0) begin
               st = ids_pkg::ST_EMPTY;
            end else begin
               do_close = 1'b1;
               gap_pos  = (req_ff.command == ids_pkg::CMD_POP_FRONT) ? '0 : count_ff - 1'b1;
            end
         end
         default: begin
            st = hit ? ids_pkg::ST_OK : ids_pkg::ST_NOTFOUND;
         end
      endcase
   end

   // read port and first-match search over the cells
   always_comb begin
      rd_val  = cell_ff[gap_pos[IW-1:0]];
      hit     = 1'b0;
      hit_idx = '0;
      for (int k = N - 1; k >= 0; k--) begin
         if (CW'(k) < count_ff && cell_ff[k] == sval) begin
            hit     = 1'b1;
            hit_idx = IW'(k);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.op == ids_pkg::OP_SHIFT && do_open) count_in = count_ff + 1'b1;
      if (ctl.op == ids_pkg::OP_SHIFT && do_close) count_in = count_ff - 1'b1;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // request capture and cell chain shifts
   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req_data;
      for (int k = 0; k < N; k++) begin
         if (ctl.op == ids_pkg::OP_SHIFT && do_open) begin
            if (CW'(k) == gap_pos) cell_ff[k] <= sval;
            else if (CW'(k) > gap_pos && k > 0) cell_ff[k] <= cell_ff[(k + N - 1) % N];
         end else if (ctl.op == ids_pkg::OP_SHIFT && do_close) begin
            if (CW'(k) >= gap_pos && k < N - 1) cell_ff[k] <= cell_ff[(k + 1) % N];
         end
      end
   end

   // result item, formed alongside the shift
   always_ff @(posedge clock) begin
      if (ctl.respond) begin
         rsp_ff.result_value <= (st == ids_pkg::ST_OK && req_ff.command != ids_pkg::CMD_FIND
                                 && !do_open) ? 32'(rd_val) : '0;
         rsp_ff.found_index  <= (req_ff.command == ids_pkg::CMD_FIND && hit) ? 4'(hit_idx) : '0;
         rsp_ff.entry_count  <= 5'(count_in);
         rsp_ff.status       <= 3'(st);
      end
   end

   assign sts.count = count_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/ids_control.sv
// Controller: accepts an item, runs the shift step and hands over the result item
module ids_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ids_pkg::ctl_type ctl
);

   typedef enum logic [1:0] {S_IDLE, S_EXEC} state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      ctl      = '{load: 1'b0, op: ids_pkg::OP_NONE, respond: 1'b0};
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // result register must be free or freeing this cycle
            if (!valid_ff || !rsp_stall) begin
               ctl.op      = ids_pkg::OP_SHIFT;
               ctl.respond = 1'b1;
               valid_in    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

FILE: src/ids_checker.sv
// Port checker for the indexed deque store, bound to the top level
module ids_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ids_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= 5'(ids_pkg::Capacity))
      else $error("entry count beyond capacity");

   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted in consecutive cycles");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ids_pkg::ST_OK |->
      rsp_data.result_value == '0 && rsp_data.found_index == '0)
      else $error("failed command returned data");

endmodule

bind indexed_deque_store_unit ids_checker u_ids_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
